/* src/fbr_pkg.sv */
// shared types and constants of the frame receiver
package fbr_pkg;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int PLEN_W   = 16;
  localparam int PHASE_W  = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDRESS = 2'd2;

  // configuration reset values
  localparam logic [BYTE_W-1:0] FRAME_START_RST  = 8'h1E;
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST  = 8'h0C;
  localparam logic [BYTE_W-1:0] PEER_ADDRESS_RST = 8'h00;

  // receive phases
  localparam logic [PHASE_W-1:0] PH_WAIT = 4'd0;
  localparam logic [PHASE_W-1:0] PH_DEST = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SRC  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_CMD  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_LENH = 4'd4;
  localparam logic [PHASE_W-1:0] PH_LENL = 4'd5;
  localparam logic [PHASE_W-1:0] PH_DATA = 4'd6;
  localparam logic [PHASE_W-1:0] PH_SEQ  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_PAD  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_CKE  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_CKO  = 4'd10;

  // report status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_DEST   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SOURCE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EVEN_CKSUM = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ODD_CKSUM  = 3'd7;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

endpackage

/* src/fbr_in_if.sv */
// received byte channel
interface fbr_in_if;
  logic                       valid;
  logic                       ready;
  logic [fbr_pkg::BYTE_W-1:0] rx_byte;
  logic                       timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

/* src/fbr_out_if.sv */
// result channel: forwarded payload bytes and frame reports
interface fbr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fbr_pkg::BYTE_W-1:0]   payload_byte;
  logic [fbr_pkg::BYTE_W-1:0]   command;
  logic [fbr_pkg::PLEN_W-1:0]   payload_length;
  logic [fbr_pkg::BYTE_W-1:0]   sequence_res;
  logic [fbr_pkg::STATUS_W-1:0] status;

  modport source (output valid, output kind, output payload_byte, output command,
                  output payload_length, output sequence_res, output status,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input command,
                  input payload_length, input sequence_res, input status,
                  output ready);
endinterface

/* src/fbus_frame_receiver_top.sv */
// frame receiver with dual xor checksums, top level
//
// usage:
//   rx  : one received byte per transaction, or a timeout mark (timed_out high)
//   res : at most one result per input transaction; kind 0 forwards a payload
//         byte, kind 1 reports frame end (status 0) or the first error
//   cfg : write port for start byte, own address and peer address; write
//         only while the block is idle
// latency: a result appears on res one cycle after its byte is taken
// throughput: one byte per cycle; the frame state and both checksums update
//   in the same cycle the byte is taken, and the result lands in one output
//   register
// stall: while res holds an untaken result, rx.ready drops; when res.ready
//   is high the next byte is taken in the same cycle the result leaves
// reset: phase returns to waiting for the start byte, all frame state clears,
//   the output register empties and the configuration takes its defaults
module fbus_frame_receiver_top #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  fbr_in_if.sink                       rx,
  fbr_out_if.source                    res,
  input  logic                         cfg_we,
  input  logic [fbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbr_pkg::BYTE_W-1:0]   cfg_data
);
  import fbr_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] frame_start_byte;
  logic [BYTE_W-1:0] own_address;
  logic [BYTE_W-1:0] peer_address;

  // frame state
  logic [PHASE_W-1:0]     phase, phase_next;
  logic [BYTE_W-1:0]      frame_command, frame_command_next;
  logic [LENGTH_BITS-1:0] length_field, length_field_next;
  logic [LENGTH_BITS-1:0] byte_index, byte_index_next;
  logic [BYTE_W-1:0]      frame_sequence, frame_sequence_next;
  logic [BYTE_W-1:0]      even_xor, even_xor_next;
  logic [BYTE_W-1:0]      odd_xor, odd_xor_next;

  // output register
  logic                out_valid;
  logic                out_kind;
  logic [BYTE_W-1:0]   out_payload_byte;
  logic [BYTE_W-1:0]   out_command;
  logic [PLEN_W-1:0]   out_payload_length;
  logic [BYTE_W-1:0]   out_sequence;
  logic [STATUS_W-1:0] out_status;

  // combinational result
  logic                emit;
  logic                rep;
  logic                r_kind;
  logic [BYTE_W-1:0]   r_payload_byte;
  logic [STATUS_W-1:0] r_status;
  logic [PLEN_W-1:0]   r_payload_length;
  logic [BYTE_W-1:0]   r_sequence;
  logic [BYTE_W-1:0]   r_command;

  logic                   rx_fire;
  logic [BYTE_W-1:0]      b;
  logic                   to;
  logic [LENGTH_BITS-1:0] plen;
  logic [LENGTH_BITS-1:0] idx_inc;
  logic [PLEN_W-1:0]      len_hi;
  logic [LENGTH_BITS-1:0] len_sum;

  assign rx.ready = !out_valid || res.ready;
  assign rx_fire  = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign to       = rx.timed_out;

  // payload count of the current length field (length minus one)
  assign plen    = length_field - LENGTH_BITS'(1);
  assign idx_inc = byte_index + LENGTH_BITS'(1);
  assign len_hi  = {b, 8'h00};
  assign len_sum = length_field + LENGTH_BITS'(b);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start_byte <= FRAME_START_RST;
      own_address      <= OWN_ADDRESS_RST;
      peer_address     <= PEER_ADDRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_START:  frame_start_byte <= cfg_data;
        CFG_OWN_ADDRESS:  own_address      <= cfg_data;
        CFG_PEER_ADDRESS: peer_address     <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame parser: next state and result for one byte
  always_comb begin
    phase_next          = phase;
    frame_command_next  = frame_command;
    length_field_next   = length_field;
    byte_index_next     = byte_index;
    frame_sequence_next = frame_sequence;
    even_xor_next       = even_xor;
    odd_xor_next        = odd_xor;
    emit                = 1'b0;
    rep                 = 1'b0;
    r_kind              = KIND_PAYLOAD;
    r_payload_byte      = '0;
    r_status            = ST_OK;
    r_payload_length    = '0;
    r_sequence          = '0;
    r_command           = '0;

    unique case (phase)
      PH_WAIT: begin
        if (to || b != frame_start_byte) begin
          rep      = 1'b1;
          r_status = ST_BAD_START;
        end else begin
          frame_command_next  = '0;
          length_field_next   = '0;
          byte_index_next     = '0;
          frame_sequence_next = '0;
          odd_xor_next        = '0;
          even_xor_next       = b;
          phase_next          = PH_DEST;
        end
      end
      PH_DEST: begin
        if (to || b != own_address) begin
          rep      = 1'b1;
          r_status = ST_BAD_DEST;
        end else begin
          odd_xor_next = odd_xor ^ b;
          phase_next   = PH_SRC;
        end
      end
      PH_SRC: begin
        if (to || b != peer_address) begin
          rep      = 1'b1;
          r_status = ST_BAD_SOURCE;
        end else begin
          even_xor_next = even_xor ^ b;
          phase_next    = PH_CMD;
        end
      end
      PH_CMD: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          frame_command_next = b;
          odd_xor_next       = odd_xor ^ b;
          phase_next         = PH_LENH;
        end
      end
      PH_LENH: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          length_field_next = len_hi[LENGTH_BITS-1:0];
          even_xor_next     = even_xor ^ b;
          phase_next        = PH_LENL;
        end
      end
      PH_LENL: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          length_field_next = len_sum;
          odd_xor_next      = odd_xor ^ b;
          byte_index_next   = '0;
          if (len_sum == '0) begin
            rep      = 1'b1;
            r_status = ST_ZERO_LEN;
          end else if (len_sum != LENGTH_BITS'(1)) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_SEQ;
          end
        end
      end
      PH_DATA: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          if (byte_index[0]) odd_xor_next = odd_xor ^ b;
          else               even_xor_next = even_xor ^ b;
          byte_index_next  = idx_inc;
          emit             = 1'b1;
          r_kind           = KIND_PAYLOAD;
          r_payload_byte   = b;
          r_command        = frame_command;
          r_payload_length = PLEN_W'(plen);
          if (idx_inc >= plen) phase_next = PH_SEQ;
        end
      end
      PH_SEQ: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          frame_sequence_next = b;
          if (byte_index[0]) odd_xor_next = odd_xor ^ b;
          else               even_xor_next = even_xor ^ b;
          byte_index_next = idx_inc;
          phase_next      = length_field[0] ? PH_PAD : PH_CKE;
        end
      end
      PH_PAD: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          if (byte_index[0]) odd_xor_next = odd_xor ^ b;
          else               even_xor_next = even_xor ^ b;
          byte_index_next = idx_inc;
          phase_next      = PH_CKE;
        end
      end
      PH_CKE: begin
        if (to) begin
          rep      = 1'b1;
          r_status = ST_TIMEOUT;
        end else begin
          // zero when the even checksum matches
          even_xor_next = even_xor ^ b;
          phase_next    = PH_CKO;
        end
      end
      PH_CKO: begin
        rep = 1'b1;
        if (to)                        r_status = ST_TIMEOUT;
        else if (even_xor != '0)       r_status = ST_EVEN_CKSUM;
        else if ((odd_xor ^ b) != '0)  r_status = ST_ODD_CKSUM;
        else                           r_status = ST_OK;
      end
      default: begin
        phase_next          = PH_WAIT;
        frame_command_next  = '0;
        length_field_next   = '0;
        byte_index_next     = '0;
        frame_sequence_next = '0;
        even_xor_next       = '0;
        odd_xor_next        = '0;
      end
    endcase

    // report: take the frame fields, then clear the frame
    if (rep) begin
      emit             = 1'b1;
      r_kind           = KIND_REPORT;
      r_command        = frame_command_next;
      r_sequence       = frame_sequence_next;
      r_payload_length = (length_field_next == '0) ? '0
                         : PLEN_W'(length_field_next - LENGTH_BITS'(1));
      phase_next          = PH_WAIT;
      frame_command_next  = '0;
      length_field_next   = '0;
      byte_index_next     = '0;
      frame_sequence_next = '0;
      even_xor_next       = '0;
      odd_xor_next        = '0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      frame_command  <= '0;
      length_field   <= '0;
      byte_index     <= '0;
      frame_sequence <= '0;
      even_xor       <= '0;
      odd_xor        <= '0;
    end else if (rx_fire) begin
      phase          <= phase_next;
      frame_command  <= frame_command_next;
      length_field   <= length_field_next;
      byte_index     <= byte_index_next;
      frame_sequence <= frame_sequence_next;
      even_xor       <= even_xor_next;
      odd_xor        <= odd_xor_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_fire) begin
      out_valid <= emit;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (rx_fire && emit) begin
      out_kind           <= r_kind;
      out_payload_byte   <= r_payload_byte;
      out_command        <= r_command;
      out_payload_length <= r_payload_length;
      out_sequence       <= r_sequence;
      out_status         <= r_status;
    end
  end

  assign res.valid          = out_valid;
  assign res.kind           = out_kind;
  assign res.payload_byte   = out_payload_byte;
  assign res.command        = out_command;
  assign res.payload_length = out_payload_length;
  assign res.sequence_res   = out_sequence;
  assign res.status         = out_status;

  // checks

  // a forwarded payload byte carries no status and no sequence
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_PAYLOAD |-> res.status == ST_OK && res.sequence_res == '0)
    else $error("payload result with report fields set");

  // every report sends the parser back to waiting for a start byte
  assert property (@(posedge clk) disable iff (rst)
    rx_fire && rep |=> phase == PH_WAIT && even_xor == '0 && odd_xor == '0)
    else $error("frame state not cleared after report");

  // payload bytes come only out of the data phase
  assert property (@(posedge clk) disable iff (rst)
    rx_fire && phase != PH_DATA |=> !res.valid || res.kind == KIND_REPORT)
    else $error("payload result outside data phase");

  // in the data phase the byte count stays below the payload count
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> byte_index < plen && length_field != '0)
    else $error("byte index beyond payload length");

endmodule
